// ----- sv/dxs_pkg.sv -----
// dxs_pkg: shared types, constants and the microcode table of the
// descending exchange sort core. Depends on nothing.
package dxs_pkg;

   localparam int DEFAULT_MAX_RECORDS = 32;
   localparam int DEFAULT_KEY_BITS    = 16;
   localparam int SCORE_BITS          = 16;
   localparam int TAG_BITS            = 5;

   typedef struct packed {
      logic [SCORE_BITS-1:0] score;
      logic [TAG_BITS-1:0]   tag;
      logic                  final_item;
   } req_type;

   typedef struct packed {
      logic [SCORE_BITS-1:0] sorted_score;
      logic [TAG_BITS-1:0]   sorted_tag;
      logic                  end_of_run;
      logic                  overflowed;
   } rsp_type;

   // Step addresses of the microprogram.
   localparam int PC_BITS = 3;
   typedef logic [PC_BITS-1:0] pc_type;

   localparam pc_type PC_LOAD    = 3'd0;
   localparam pc_type PC_READ_A  = 3'd1;
   localparam pc_type PC_LATCH_A = 3'd2;
   localparam pc_type PC_TEST_B  = 3'd3;
   localparam pc_type PC_COMPARE = 3'd4;
   localparam pc_type PC_EMIT    = 3'd5;

   // Jump conditions.
   typedef logic [1:0] cond_type;

   localparam cond_type COND_ALWAYS = 2'd0;
   localparam cond_type COND_FINAL  = 2'd1;
   localparam cond_type COND_B_END  = 2'd2;
   localparam cond_type COND_LAST   = 2'd3;

   typedef struct packed {
      logic     take_req;   // open the request channel, load records
      logic     rd_a;       // read store at outer position
      logic     init_b;     // inner position starts right after outer
      logic     rd_b;       // read store at inner position
      logic     cur_load;   // latch the outer entry
      logic     cmp_step;   // compare, swap, advance inner position
      logic     emit;       // push the finished entry to the output
      cond_type cond;
      pc_type   jump_pc;    // taken when the condition holds
      pc_type   next_pc;    // taken otherwise
   } uword_type;

   // Status from the datapath that the sequencer branches on.
   typedef struct packed {
      logic final_acc;      // a request marked final was taken
      logic b_end;          // inner position reached the loaded count
      logic last;           // outer position is the last loaded entry
      logic hold;           // output register still full, stay put
   } seq_status_type;

   function automatic uword_type ucode_rom(input pc_type pc);
      uword_type w;
      w = '0;
      unique case (pc)
         PC_LOAD: begin
            w.take_req = 1'b1;
            w.cond     = COND_FINAL;
            w.jump_pc  = PC_READ_A;
            w.next_pc  = PC_LOAD;
         end
         PC_READ_A: begin
            w.rd_a    = 1'b1;
            w.init_b  = 1'b1;
            w.cond    = COND_ALWAYS;
            w.jump_pc = PC_LATCH_A;
            w.next_pc = PC_LATCH_A;
         end
         PC_LATCH_A: begin
            w.cur_load = 1'b1;
            w.cond     = COND_ALWAYS;
            w.jump_pc  = PC_TEST_B;
            w.next_pc  = PC_TEST_B;
         end
         PC_TEST_B: begin
            w.rd_b    = 1'b1;
            w.cond    = COND_B_END;
            w.jump_pc = PC_EMIT;
            w.next_pc = PC_COMPARE;
         end
         PC_COMPARE: begin
            w.cmp_step = 1'b1;
            w.cond     = COND_ALWAYS;
            w.jump_pc  = PC_TEST_B;
            w.next_pc  = PC_TEST_B;
         end
         PC_EMIT: begin
            w.emit    = 1'b1;
            w.cond    = COND_LAST;
            w.jump_pc = PC_LOAD;
            w.next_pc = PC_READ_A;
         end
         default: begin
            w.cond    = COND_ALWAYS;
            w.jump_pc = PC_LOAD;
            w.next_pc = PC_LOAD;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- sv/dxs_ram.sv -----
// dxs_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dxs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/dxs_useq.sv -----
// dxs_useq: microcode sequencer, step counter plus control word table.
// Depends on dxs_pkg (ucode_rom, step and condition codes).
module dxs_useq (
   input  logic                    clock,
   input  logic                    reset,
   input  dxs_pkg::seq_status_type status,
   output dxs_pkg::uword_type      uword
);
   import dxs_pkg::*;

   pc_type    pc_ff;
   pc_type    pc_in;
   uword_type uw;
   logic      taken;

   assign uw = ucode_rom(pc_ff);

   always_comb begin
      unique case (uw.cond)
         COND_ALWAYS: taken = 1'b1;
         COND_FINAL:  taken = status.final_acc;
         COND_B_END:  taken = status.b_end;
         COND_LAST:   taken = status.last;
         default:     taken = 1'b1;
      endcase
   end

   always_comb begin
      priority if (status.hold) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = uw.jump_pc;
      end else begin
         pc_in = uw.next_pc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign uword = uw;

endmodule

// ----- sv/descending_exchange_sort_core.sv -----
// descending_exchange_sort_core: loads records, sorts them by descending score
// and emits them. Depends on dxs_pkg, dxs_ram and dxs_useq.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  dxs_pkg::req_type (score, tag, final_item)
//   rsp_      out        rsp_valid / rsp_stall  dxs_pkg::rsp_type (sorted record, flags)
//
// Loading: one request per cycle. After the final request the pace of the
//   sort is set by the single read port of the record store: every inner
//   compare costs a read step and a compare/swap step.
// Reset: clears the sequencer, fill count, overflow flag and output valid; the
//   store needs no clearing pass, only loaded entries are ever read.
// Stalls: req_stall is high whenever the sequencer is not in its load step;
//   rsp_stall holds the output register and freezes the sequencer at its
//   emit step until the register frees up.
module descending_exchange_sort_core #(
   parameter int MAX_RECORDS = dxs_pkg::DEFAULT_MAX_RECORDS,
   parameter int KEY_BITS    = dxs_pkg::DEFAULT_KEY_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dxs_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dxs_pkg::rsp_type rsp_payload
);
   import dxs_pkg::*;

   localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
   localparam int IDX_W  = $clog2(MAX_RECORDS);
   localparam int DATA_W = KEY_BITS + TAG_BITS;

   uword_type      uw;
   seq_status_type status;

   // Fill count and overflow flag of the current set.
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in;
   // Outer position a, inner position b, entry held for position a.
   logic [IDX_W-1:0]  a_ff, a_in;
   logic [CNT_W-1:0]  b_ff, b_in;
   logic [DATA_W-1:0] cur_ff, cur_in;
   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;

   logic              req_fire;
   logic              full;
   logic              b_end;
   logic              last;
   logic              out_free;
   logic              emit_fire;
   logic              greater;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic              ram_re;
   logic [IDX_W-1:0]  ram_raddr;
   logic [DATA_W-1:0] ram_rdata;

   dxs_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .uword  (uw)
   );

   dxs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_RECORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Accept requests only in the load step.
   assign req_stall = !uw.take_req;
   assign req_fire  = req_valid && uw.take_req;
   assign full      = (cnt_ff == CNT_W'(MAX_RECORDS));

   // Loop bounds: inner scan ends at the fill count, outer pass at the last entry.
   assign b_end = (b_ff == cnt_ff);
   assign last  = ((CNT_W'(a_ff) + CNT_W'(1)) == cnt_ff);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_fire = uw.emit && out_free;

   // Strictly greater moves the entry at b up, so an entry equal to the held one is never swapped with it.
   assign greater = ram_rdata[TAG_BITS +: KEY_BITS] > cur_ff[TAG_BITS +: KEY_BITS];

   always_comb begin
      status.final_acc = req_fire && req_payload.final_item;
      status.b_end     = b_end;
      status.last      = last;
      status.hold      = uw.emit && !out_free;
   end

   // Store ports: the load step writes at the fill count, a compare step
   // writes the displaced outer entry back at b. Reads go to a or b.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = b_ff[IDX_W-1:0];
      ram_wdata = cur_ff;
      if (uw.take_req) begin
         ram_we    = req_fire && !full;
         ram_waddr = cnt_ff[IDX_W-1:0];
         ram_wdata = {KEY_BITS'(req_payload.score), req_payload.tag};
      end else if (uw.cmp_step) begin
         ram_we = greater;
      end
   end

   assign ram_re    = uw.rd_a || (uw.rd_b && !b_end);
   assign ram_raddr = uw.rd_a ? a_ff : b_ff[IDX_W-1:0];

   always_comb begin
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      cur_in = cur_ff;

      // Load: store the record or, when full, drop it and flag the set.
      if (req_fire) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
      if (uw.take_req) begin
         a_in = '0;
      end

      if (uw.init_b) begin
         b_in = CNT_W'(a_ff) + CNT_W'(1);
      end
      if (uw.cur_load) begin
         cur_in = ram_rdata;
      end
      // Compare: swap through the held entry, then advance b.
      if (uw.cmp_step) begin
         if (greater) begin
            cur_in = ram_rdata;
         end
         b_in = b_ff + CNT_W'(1);
      end

      // Emit: position a is final once its inner scan is done.
      if (emit_fire) begin
         if (last) begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            a_in = a_ff + IDX_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (emit_fire) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.sorted_score = SCORE_BITS'(cur_ff[TAG_BITS +: KEY_BITS]);
         rsp_payload_in.sorted_tag   = cur_ff[TAG_BITS-1:0];
         rsp_payload_in.end_of_run   = last;
         rsp_payload_in.overflowed   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff           <= a_in;
      b_ff           <= b_in;
      cur_ff         <= cur_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Fill count never passes capacity.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RECORDS))
      else $error("fill count above capacity");

   // Sorting and emission only ever run on a non-empty set.
   assert property (@(posedge clock) disable iff (reset)
      !uw.take_req |-> cnt_ff != '0)
      else $error("sequencer left load step with empty set");

   // Inner position stays strictly between outer position and fill count.
   assert property (@(posedge clock) disable iff (reset)
      uw.cmp_step |-> (b_ff < cnt_ff) && (CNT_W'(a_ff) < b_ff))
      else $error("inner position out of range during compare");

   // Emitting the last record empties the set.
   assert property (@(posedge clock) disable iff (reset)
      emit_fire && last |=> cnt_ff == '0 && !ovf_ff)
      else $error("set not cleared after last record");

endmodule

// ----- verif/dxs_sort_checker.sv -----
// dxs_sort_checker: watches both channels of the exchange sort core, predicts
// the sorted records of every set and compares them. Depends on dxs_pkg.
module dxs_sort_checker #(
   parameter int MAX_RECORDS = dxs_pkg::DEFAULT_MAX_RECORDS,
   parameter int KEY_BITS    = dxs_pkg::DEFAULT_KEY_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  dxs_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  dxs_pkg::rsp_type rsp_payload,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] KEY_MASK = (KEY_BITS >= 32) ? 32'hFFFF_FFFF :
                                      ((32'h1 << KEY_BITS) - 32'h1);

   logic [31:0]                  key_mem [MAX_RECORDS];
   logic [dxs_pkg::TAG_BITS-1:0] tag_mem [MAX_RECORDS];
   int                           fill;
   logic                         dropped;
   dxs_pkg::rsp_type             sorted_q [$];
   int                           mismatches;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      mismatches    = 0;
      fill          = 0;
      dropped       = 1'b0;
   end

   // Sort the loaded entries in place, highest key first; equal keys keep
   // the order that the pairwise swaps leave them in.
   task automatic sort_and_queue();
      logic [31:0]                  k;
      logic [dxs_pkg::TAG_BITS-1:0] t;
      dxs_pkg::rsp_type             r;
      for (int a = 0; a < fill; a++) begin
         for (int b = a; b < fill; b++) begin
            if (key_mem[b] > key_mem[a]) begin
               k = key_mem[a];
               t = tag_mem[a];
               key_mem[a] = key_mem[b];
               tag_mem[a] = tag_mem[b];
               key_mem[b] = k;
               tag_mem[b] = t;
            end
         end
      end
      for (int i = 0; i < fill; i++) begin
         r.sorted_score = key_mem[i][dxs_pkg::SCORE_BITS-1:0];
         r.sorted_tag   = tag_mem[i];
         r.end_of_run   = (i == fill - 1);
         r.overflowed   = dropped;
         sorted_q.push_back(r);
      end
      fill    = 0;
      dropped = 1'b0;
   endtask

   task automatic take_record(input dxs_pkg::req_type r);
      if (fill < MAX_RECORDS) begin
         key_mem[fill] = 32'(r.score) & KEY_MASK;
         tag_mem[fill] = r.tag;
         fill++;
      end else begin
         dropped = 1'b1;
      end
      if (r.final_item)
         sort_and_queue();
   endtask

   task automatic check_record(input dxs_pkg::rsp_type got);
      dxs_pkg::rsp_type want;
      if (sorted_q.size() == 0) begin
         if (mismatches < 10)
            $display("%0t: unexpected record score=%h tag=%h end=%b ovf=%b", $realtime,
                     got.sorted_score, got.sorted_tag, got.end_of_run, got.overflowed);
         mismatches++;
      end else begin
         want = sorted_q.pop_front();
         if (got.sorted_score !== want.sorted_score || got.sorted_tag !== want.sorted_tag ||
             got.end_of_run !== want.end_of_run || got.overflowed !== want.overflowed) begin
            if (mismatches < 10)
               $display("%0t: mismatch exp s=%h t=%h e=%b o=%b got s=%h t=%h e=%b o=%b",
                        $realtime, want.sorted_score, want.sorted_tag, want.end_of_run,
                        want.overflowed, got.sorted_score, got.sorted_tag, got.end_of_run,
                        got.overflowed);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill    = 0;
         dropped = 1'b0;
         sorted_q.delete();
      end else begin
         if (req_valid && !req_stall)
            take_record(req_payload);
         if (rsp_valid && !rsp_stall)
            check_record(rsp_payload);
      end
      fail_count    <= mismatches;
      pending_count <= sorted_q.size();
   end

endmodule

// ----- verif/tb.sv -----
// tb: top of the exchange sort core testbench; drives request sets and output
// stalls and gives the verdict. Depends on dxs_pkg, the core and dxs_sort_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Longest quiet stretch: the first outer pass of a full set before its first
   // record, plus the longest output stall; keep far more than that as headroom.
   localparam int IDLE_LIMIT   = 8000;
   localparam int RANDOM_ITEMS = 300;
   localparam int DRAIN_CYCLES = 30;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   dxs_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   dxs_pkg::rsp_type rsp_payload;

   int fail_count;
   int pending_count;
   int idle_cycles = 0;
   int items_sent  = 0;
   bit no_idle     = 1'b0;

   descending_exchange_sort_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   dxs_sort_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap length: mostly none or a few cycles, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Key choice: a small pool to force ties, the two extremes, or anything.
   function automatic logic [15:0] pick_score();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3)
         return 16'($urandom_range(0, 3));
      else if (r == 3)
         return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else
         return 16'($urandom_range(0, 65535));
   endfunction

   // Set size: mostly small sets, some medium, a few near or past the capacity
   // of the store (past it, the final request gets dropped).
   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 6);
      else if (r < 92)
         return $urandom_range(7, 20);
      else
         return $urandom_range(30, 36);
   endfunction

   // Output side: alternate free and stalled runs of random length; hold the
   // stall low during reset and in sets that run without idling.
   int stall_run = 0;
   always @(negedge clock) begin
      if (reset || no_idle) begin
         rsp_stall = 1'b0;
         stall_run = 0;
      end else if (stall_run > 0) begin
         stall_run--;
      end else if (rsp_stall) begin
         rsp_stall = 1'b0;
         stall_run = $urandom_range(0, 6);
      end else begin
         rsp_stall = 1'b1;
         stall_run = pick_gap();
      end
   end

   // Watchdog: count cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // Offer one request at a falling edge, hold it until taken at a rising
   // edge, then step to the next falling edge. Keep valid high across
   // back-to-back requests.
   task automatic send_record(input logic [15:0] score, input logic [4:0] tag,
                              input logic fin);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload = '{score: score, tag: tag, final_item: fin};
      req_valid   = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_set(input int size);
      for (int i = 0; i < size; i++)
         send_record(pick_score(), 5'($urandom_range(0, 31)), i == size - 1);
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Single-record sets at both ends of the key and tag ranges.
      send_record(16'h0000, 5'd0, 1'b1);
      send_record(16'hFFFF, 5'd31, 1'b1);
      // All keys equal: the tag order shows how ties settle.
      send_record(16'd5, 5'd1, 1'b0);
      send_record(16'd5, 5'd2, 1'b0);
      send_record(16'd5, 5'd3, 1'b0);
      send_record(16'd5, 5'd4, 1'b1);
      // Ascending and already descending input.
      send_record(16'd1, 5'd10, 1'b0);
      send_record(16'd2, 5'd11, 1'b0);
      send_record(16'd3, 5'd12, 1'b1);
      send_record(16'd300, 5'd7, 1'b0);
      send_record(16'd200, 5'd8, 1'b0);
      send_record(16'd100, 5'd9, 1'b1);
      // Interleaved ties with both extremes in one set.
      send_record(16'd7, 5'd0, 1'b0);
      send_record(16'd9, 5'd1, 1'b0);
      send_record(16'd7, 5'd2, 1'b0);
      send_record(16'd9, 5'd3, 1'b0);
      send_record(16'h0000, 5'd4, 1'b0);
      send_record(16'hFFFF, 5'd5, 1'b1);

      // Random sets: open with one that overflows the store, then draw sizes;
      // about one set in six runs without any idling on either side.
      items_sent = 0;
      send_set(34);
      while (items_sent < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 5) == 0);
         send_set(pick_size());
      end
      no_idle   = 1'b0;
      req_valid = 1'b0;

      // Drain every expected record, then let the core settle.
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
